@@ sv/hsv2rgb_pkg.sv @@
// hsv2rgb_pkg: shared types and the sector-to-channel mapping for the hsv to rgb converter
package hsv2rgb_pkg;

  // number of hue sectors around the color circle
  localparam int SECTOR_COUNT = 6;

  // which term drives a channel
  typedef enum logic [1:0] {
    SEL_V,
    SEL_P,
    SEL_Q,
    SEL_T
  } sel_t;

  // hue sector, named by the pair of primaries/secondaries it spans
  typedef enum logic [2:0] {
    SECT_R_Y,
    SECT_Y_G,
    SECT_G_C,
    SECT_C_B,
    SECT_B_M,
    SECT_M_R
  } sector_t;

  typedef struct packed {
    sel_t red;
    sel_t green;
    sel_t blue;
  } chan_sel_t;

  function automatic chan_sel_t sector_map(sector_t sector);
    chan_sel_t s;
    case (sector)
      SECT_R_Y: s = '{red: SEL_V, green: SEL_T, blue: SEL_P};
      SECT_Y_G: s = '{red: SEL_Q, green: SEL_V, blue: SEL_P};
      SECT_G_C: s = '{red: SEL_P, green: SEL_V, blue: SEL_T};
      SECT_C_B: s = '{red: SEL_P, green: SEL_Q, blue: SEL_V};
      SECT_B_M: s = '{red: SEL_T, green: SEL_P, blue: SEL_V};
      SECT_M_R: s = '{red: SEL_V, green: SEL_P, blue: SEL_Q};
      default:  s = '{red: SEL_V, green: SEL_P, blue: SEL_P};
    endcase
    return s;
  endfunction

endpackage

@@ sv/hsv2rgb_if.sv @@
// hsv2rgb_in_if / hsv2rgb_out_if: valid/ready channels for hsv words and rgb words
interface hsv2rgb_in_if #(
  parameter int CHANNEL_BITS = 8
) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness, input ready);
  modport sink (input valid, input hue, input saturation, input brightness, output ready);
endinterface

interface hsv2rgb_out_if #(
  parameter int CHANNEL_BITS = 8
) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

@@ sv/hsv2rgb_divm.sv @@
// hsv2rgb_divm: exact floor division by 2^N - 1 for dividends below (2^N - 1) * 2^N
module hsv2rgb_divm #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic [2*CHANNEL_BITS-1:0] dividend,
  output logic [CHANNEL_BITS-1:0]   quotient
);

  localparam int N = CHANNEL_BITS;

  logic [2*N:0] sum;

  // w / (2^N - 1) = (w + (w >> N) + 1) >> N in this range
  always_comb begin
    sum = {1'b0, dividend} + (2*N+1)'(dividend >> N) + (2*N+1)'(1);
    quotient = sum[2*N-1:N];
  end

endmodule

@@ sv/hsv_to_rgb_convert.sv @@
// hsv_to_rgb_convert: five-stage pipelined hsv to rgb color converter
//
//   channel  dir  handshake            word
//   in_ch    in   valid/ready          hue, saturation, brightness
//   out_ch   out  valid/ready          red, green, blue
//
// one word per clock while out_ch.ready holds; a word passes stage registers 1 to 5 in order
// stages: sector and v*(M-s), p and q/t factors, v*x, two divides by M, channel select
// each stage advances when empty or when the stage after it moves, so bubbles close up,
// even during an out_ch stall; in_ch.ready drops only when all stages are full
// reset clears the stage valid bits only
module hsv_to_rgb_convert #(
  parameter int CHANNEL_BITS = 8
) (
  input logic           clk,
  input logic           rst_n,
  hsv2rgb_in_if.sink    in_ch,
  hsv2rgb_out_if.source out_ch
);

  import hsv2rgb_pkg::*;

  localparam int N = CHANNEL_BITS;
  localparam int STAGES = 5;
  localparam logic [N-1:0]   M_N   = {N{1'b1}};
  localparam logic [N+2:0]   M_EXT = (N+3)'(M_N);
  localparam logic [2*N-1:0] M_2N  = (2*N)'(M_N);
  localparam logic [2*N-1:0] MM    = M_2N * M_2N;

  logic [STAGES:1] v_r;
  logic [STAGES:1] en;

  // stage 1 registers
  sector_t        s1_sector_r;
  logic [N-1:0]   s1_frac_r;
  logic [N-1:0]   s1_sat_r;
  logic [N-1:0]   s1_val_r;
  logic [2*N-1:0] s1_pw_r;

  // stage 2 registers
  sector_t        s2_sector_r;
  logic [N-1:0]   s2_val_r;
  logic [N-1:0]   s2_p_r;
  logic [2*N-1:0] s2_xq_r;
  logic [2*N-1:0] s2_xt_r;

  // stage 3 registers
  sector_t        s3_sector_r;
  logic [N-1:0]   s3_val_r;
  logic [N-1:0]   s3_p_r;
  logic [3*N-1:0] s3_yq_r;
  logic [3*N-1:0] s3_yt_r;

  // stage 4 registers
  sector_t        s4_sector_r;
  logic [N-1:0]   s4_val_r;
  logic [N-1:0]   s4_p_r;
  logic [2*N-1:0] s4_zq_r;
  logic [2*N-1:0] s4_zt_r;

  // output registers
  logic [N-1:0] red_r;
  logic [N-1:0] green_r;
  logic [N-1:0] blue_r;

  // handshake chain
  always_comb begin
    en[STAGES] = !v_r[STAGES] || out_ch.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready  = en[1];
  assign out_ch.valid = v_r[STAGES];
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_ch.valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: split 6*hue into sector and remainder, brightness * (M - saturation)
  logic [N+2:0]   six_h;
  logic [N+2:0]   base;
  logic [2:0]     cnt;
  sector_t        s1_sector_nxt;
  logic [N-1:0]   s1_frac_nxt;
  logic [2*N-1:0] s1_pw_nxt;

  always_comb begin
    six_h = ((N+3)'(in_ch.hue) << 2) + ((N+3)'(in_ch.hue) << 1);
    cnt   = '0;
    base  = '0;
    for (int k = 1; k <= SECTOR_COUNT; k++) begin
      if (six_h >= (N+3)'(k) * M_EXT) begin
        cnt  = 3'(k);
        base = (N+3)'(k) * M_EXT;
      end
    end
    s1_frac_nxt = N'(six_h - base);
    // full-scale hue lands one past the last sector
    if (cnt == 3'(SECTOR_COUNT)) begin
      s1_sector_nxt = SECT_R_Y;
    end else begin
      s1_sector_nxt = sector_t'(cnt);
    end
    s1_pw_nxt = (2*N)'(in_ch.brightness) * (2*N)'(M_N - in_ch.saturation);
  end

  always_ff @(posedge clk) begin
    if (en[1] && in_ch.valid) begin
      s1_sector_r <= s1_sector_nxt;
      s1_frac_r   <= s1_frac_nxt;
      s1_sat_r    <= in_ch.saturation;
      s1_val_r    <= in_ch.brightness;
      s1_pw_r     <= s1_pw_nxt;
    end
  end

  // stage 2: p, and the q/t numerator factors M*M - f*s and M*M - (M-f)*s
  logic [N-1:0]   s2_p_nxt;
  logic [2*N-1:0] s2_xq_nxt;
  logic [2*N-1:0] s2_xt_nxt;

  hsv2rgb_divm #(.CHANNEL_BITS(N)) u_div_p (
    .dividend (s1_pw_r),
    .quotient (s2_p_nxt)
  );

  always_comb begin
    s2_xq_nxt = MM - (2*N)'(s1_frac_r) * (2*N)'(s1_sat_r);
    s2_xt_nxt = MM - (2*N)'(M_N - s1_frac_r) * (2*N)'(s1_sat_r);
  end

  always_ff @(posedge clk) begin
    if (en[2] && v_r[1]) begin
      s2_sector_r <= s1_sector_r;
      s2_val_r    <= s1_val_r;
      s2_p_r      <= s2_p_nxt;
      s2_xq_r     <= s2_xq_nxt;
      s2_xt_r     <= s2_xt_nxt;
    end
  end

  // stage 3: full numerators
  logic [3*N-1:0] s3_yq_nxt;
  logic [3*N-1:0] s3_yt_nxt;

  always_comb begin
    s3_yq_nxt = (3*N)'(s2_val_r) * (3*N)'(s2_xq_r);
    s3_yt_nxt = (3*N)'(s2_val_r) * (3*N)'(s2_xt_r);
  end

  always_ff @(posedge clk) begin
    if (en[3] && v_r[2]) begin
      s3_sector_r <= s2_sector_r;
      s3_val_r    <= s2_val_r;
      s3_p_r      <= s2_p_r;
      s3_yq_r     <= s3_yq_nxt;
      s3_yt_r     <= s3_yt_nxt;
    end
  end

  // stage 4: first divide by M; y/M = hi + (hi + lo)/M with y = hi*2^N + lo
  logic [2*N-1:0] s4_sq;
  logic [2*N-1:0] s4_st;
  logic [N-1:0]   s4_cq;
  logic [N-1:0]   s4_ct;
  logic [2*N-1:0] s4_zq_nxt;
  logic [2*N-1:0] s4_zt_nxt;

  always_comb begin
    s4_sq = s3_yq_r[3*N-1:N] + (2*N)'(s3_yq_r[N-1:0]);
    s4_st = s3_yt_r[3*N-1:N] + (2*N)'(s3_yt_r[N-1:0]);
  end

  hsv2rgb_divm #(.CHANNEL_BITS(N)) u_div_q1 (
    .dividend (s4_sq),
    .quotient (s4_cq)
  );

  hsv2rgb_divm #(.CHANNEL_BITS(N)) u_div_t1 (
    .dividend (s4_st),
    .quotient (s4_ct)
  );

  always_comb begin
    s4_zq_nxt = s3_yq_r[3*N-1:N] + (2*N)'(s4_cq);
    s4_zt_nxt = s3_yt_r[3*N-1:N] + (2*N)'(s4_ct);
  end

  always_ff @(posedge clk) begin
    if (en[4] && v_r[3]) begin
      s4_sector_r <= s3_sector_r;
      s4_val_r    <= s3_val_r;
      s4_p_r      <= s3_p_r;
      s4_zq_r     <= s4_zq_nxt;
      s4_zt_r     <= s4_zt_nxt;
    end
  end

  // stage 5: second divide by M, then channel select
  logic [N-1:0] q_term;
  logic [N-1:0] t_term;
  chan_sel_t    chan_sel;
  logic [N-1:0] red_nxt;
  logic [N-1:0] green_nxt;
  logic [N-1:0] blue_nxt;

  hsv2rgb_divm #(.CHANNEL_BITS(N)) u_div_q2 (
    .dividend (s4_zq_r),
    .quotient (q_term)
  );

  hsv2rgb_divm #(.CHANNEL_BITS(N)) u_div_t2 (
    .dividend (s4_zt_r),
    .quotient (t_term)
  );

  function automatic logic [N-1:0] pick_term(sel_t sel, logic [N-1:0] v, logic [N-1:0] p,
                                             logic [N-1:0] q, logic [N-1:0] t);
    logic [N-1:0] r;
    case (sel)
      SEL_V:   r = v;
      SEL_P:   r = p;
      SEL_Q:   r = q;
      SEL_T:   r = t;
      default: r = v;
    endcase
    return r;
  endfunction

  always_comb begin
    chan_sel  = sector_map(s4_sector_r);
    red_nxt   = pick_term(chan_sel.red, s4_val_r, s4_p_r, q_term, t_term);
    green_nxt = pick_term(chan_sel.green, s4_val_r, s4_p_r, q_term, t_term);
    blue_nxt  = pick_term(chan_sel.blue, s4_val_r, s4_p_r, q_term, t_term);
  end

  always_ff @(posedge clk) begin
    if (en[5] && v_r[4]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // remainder of 6*hue over M never reaches M
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> s1_frac_r != M_N)
    else $error("hue remainder out of range");

  // p can never exceed brightness
  a_p_le_v: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> s2_p_r <= s2_val_r)
    else $error("p term above brightness");

  // a stalled stage 4 keeps its word
  a_hold_s4: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[4] && !en[5]) |=> (v_r[4] && $stable(s4_zq_r) && $stable(s4_val_r)))
    else $error("stage 4 word lost during stall");

  // every sector routes brightness to some channel
  a_v_present: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[4] && en[5]) |=> (out_ch.red == $past(s4_val_r) || out_ch.green == $past(s4_val_r)
                           || out_ch.blue == $past(s4_val_r)))
    else $error("no channel carries brightness");
`endif

endmodule
